// ----- sv/wrle_pkg.sv -----
// Package for the word run-length expander.
// Constants, widths and the result word type; no dependencies.
package wrle_pkg;

   localparam int DEFAULT_OUTPUT_CAPACITY = 256;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int LEN_W   = 9;
   localparam int WCNT_W  = 9;
   localparam int GATH_W  = 24;

   localparam logic [WORD_W-1:0] MARKER_LIMIT = 32'h8000_0000;
   localparam logic [WORD_W-1:0] MARKER_CLEAR = 32'h7fff_ffff;

   typedef struct packed {
      logic [WORD_W-1:0] word_value;
      logic [LEN_W-1:0]  run_length;
      logic              end_of_copy;
      logic [WCNT_W-1:0] words_written;
   } rsp_word_type;

endpackage

// ----- sv/wrle_if.sv -----
// Handshake channels of the word run-length expander.
// Depends on wrle_pkg for field widths.
interface wrle_req_if;
   import wrle_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wrle_rsp_if;
   import wrle_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] word_value;
   logic [LEN_W-1:0]  run_length;
   logic              end_of_copy;
   logic [WCNT_W-1:0] words_written;

   modport source (output valid, output word_value, output run_length,
                   output end_of_copy, output words_written, input ready);
   modport sink   (input valid, input word_value, input run_length,
                   input end_of_copy, input words_written, output ready);
endinterface

// ----- sv/word_run_length_expander.sv -----
// Word run-length expander top level.
// Depends on wrle_pkg and the channel interfaces in wrle_if.sv.
//
// Usage:
//   req_bus carries one source byte per transfer (data_byte, last_byte).
//   Bytes are gathered into little-endian 32-bit words; a word above
//   0x80000000 is a run marker whose next byte gives extra repeats.
//   rsp_bus carries at most one result per source byte: the word, its
//   run length (0 = no word), end_of_copy and the running word count.
//   The byte flagged last_byte always yields a result with the total and
//   returns the copy state to its reset value.
// Output: each result is registered and appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while the output is not stalled; the
//   per-byte update is combinational and feeds the state and output registers.
// Reset: synchronous, clears all copy state and the output valid.
// Stall: the output register holds its result while rsp_bus.ready is low;
//   a byte is still taken when the register is empty or being drained.
module word_run_length_expander #(
   parameter int OUTPUT_CAPACITY = wrle_pkg::DEFAULT_OUTPUT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   wrle_req_if.sink    req_bus,
   wrle_rsp_if.source  rsp_bus
);
   import wrle_pkg::*;

   localparam int CNT_W = $clog2(OUTPUT_CAPACITY + 1);
   localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
   localparam logic [SUM_W-1:0] CAP = SUM_W'(OUTPUT_CAPACITY);

   logic [GATH_W-1:0]   gather_ff, gather_in;
   logic [1:0]          pos_ff, pos_in;
   logic [WORD_W-2:0]   pend_word_ff, pend_word_in;
   logic                pend_ff, pend_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                stopped_ff, stopped_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_ff, rsp_in;

   logic                accept;
   logic                emit;
   logic [WORD_W-1:0]   word;
   logic [WORD_W-1:0]   value;
   logic [LEN_W-1:0]    len;
   logic [SUM_W-1:0]    run_sum;
   logic [SUM_W-1:0]    new_count;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign word          = {req_bus.data_byte, gather_ff};
   assign run_sum       = SUM_W'(count_ff) + SUM_W'(req_bus.data_byte) + SUM_W'(1);

   always_comb begin
      gather_in    = gather_ff;
      pos_in       = pos_ff;
      pend_word_in = pend_word_ff;
      pend_in      = pend_ff;
      stopped_in   = stopped_ff;
      emit         = 1'b0;
      value        = '0;
      len          = '0;
      if (!stopped_ff) begin
         if (pend_ff) begin
            pend_in = 1'b0;
            if (run_sum >= CAP) begin
               stopped_in = 1'b1;
            end else begin
               emit  = 1'b1;
               value = {1'b0, pend_word_ff};
               len   = LEN_W'(req_bus.data_byte) + LEN_W'(1);
            end
         end else if (pos_ff != 2'd3) begin
            case (pos_ff)
               2'd0:    gather_in[7:0]   = req_bus.data_byte;
               2'd1:    gather_in[15:8]  = req_bus.data_byte;
               default: gather_in[23:16] = req_bus.data_byte;
            endcase
            pos_in = pos_ff + 2'd1;
         end else begin
            gather_in = '0;
            pos_in    = '0;
            if (word > MARKER_LIMIT) begin
               if (req_bus.last_byte) begin
                  emit  = 1'b1;
                  value = word & MARKER_CLEAR;
                  len   = LEN_W'(1);
               end else begin
                  pend_word_in = word[WORD_W-2:0];
                  pend_in      = 1'b1;
               end
            end else begin
               emit  = 1'b1;
               value = word;
               len   = LEN_W'(1);
            end
         end
      end
      new_count = SUM_W'(count_ff) + SUM_W'(len);
      count_in  = CNT_W'(new_count);
      if (emit && (new_count >= CAP)) begin
         stopped_in = 1'b1;
      end
      rsp_in.word_value    = value;
      rsp_in.run_length    = len;
      rsp_in.end_of_copy   = req_bus.last_byte;
      rsp_in.words_written = new_count[WCNT_W-1:0];
      rsp_valid_in         = emit || req_bus.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gather_ff    <= '0;
         pos_ff       <= '0;
         pend_word_ff <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (req_bus.last_byte) begin
               gather_ff    <= '0;
               pos_ff       <= '0;
               pend_word_ff <= '0;
               pend_ff      <= 1'b0;
               count_ff     <= '0;
               stopped_ff   <= 1'b0;
            end else begin
               gather_ff    <= gather_in;
               pos_ff       <= pos_in;
               pend_word_ff <= pend_word_in;
               pend_ff      <= pend_in;
               count_ff     <= count_in;
               stopped_ff   <= stopped_in;
            end
            rsp_valid_ff <= rsp_valid_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.word_value    = rsp_ff.word_value;
   assign rsp_bus.run_length    = rsp_ff.run_length;
   assign rsp_bus.end_of_copy   = rsp_ff.end_of_copy;
   assign rsp_bus.words_written = rsp_ff.words_written;

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("output valid set after reset");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(count_ff) <= CAP)
      else $error("word count beyond capacity");

   a_pending_aligned: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (pos_ff == 2'd0))
      else $error("repeat byte expected mid-word");

   a_stopped_no_pending: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !pend_ff)
      else $error("marker pending after copy stopped");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.last_byte) |=> (rsp_valid_ff && rsp_ff.end_of_copy))
      else $error("last byte without end-of-copy result");

endmodule

// ----- verif/wrle_expand_check.sv -----
`timescale 1ns / 100ps
// Checker for the word run-length expander: watches both channels, predicts
// each rsp word from the accepted source bytes and compares field by field.
// Depends on wrle_pkg and the channel interfaces in wrle_if.sv.
module wrle_expand_check #(
   parameter int OUTPUT_CAPACITY = wrle_pkg::DEFAULT_OUTPUT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   wrle_req_if         req_mon,
   wrle_rsp_if         rsp_mon,
   output int unsigned mismatches,
   output int unsigned pending_rsp_words
);
   import wrle_pkg::*;

   logic [GATH_W-1:0] gather_bytes;
   logic [1:0]        gather_pos;
   logic [WORD_W-2:0] run_word;
   logic              run_armed;
   int unsigned       dest_count;
   logic              dest_full;
   rsp_word_type      expected_rsp[$];

   function automatic void clear_copy_state();
      gather_bytes = '0;
      gather_pos   = '0;
      run_word     = '0;
      run_armed    = 1'b0;
      dest_count   = 0;
      dest_full    = 1'b0;
   endfunction

   // One source byte in; returns 1 when it yields an rsp word.
   function automatic bit expand_byte(input logic [BYTE_W-1:0] b, input logic last,
                                      output rsp_word_type rsp);
      logic [WORD_W-1:0] word;
      bit                emit;
      emit = 1'b0;
      rsp  = '0;
      if (!dest_full) begin
         if (run_armed) begin
            run_armed = 1'b0;
            if (dest_count + b + 1 >= OUTPUT_CAPACITY) begin
               dest_full = 1'b1;
            end else begin
               emit            = 1'b1;
               rsp.word_value  = {1'b0, run_word};
               rsp.run_length  = LEN_W'(b + 1);
            end
         end else if (gather_pos != 2'd3) begin
            gather_bytes[8*gather_pos +: 8] = b;
            gather_pos++;
         end else begin
            word         = {b, gather_bytes};
            gather_bytes = '0;
            gather_pos   = '0;
            if (word > MARKER_LIMIT && !last) begin
               run_word  = word[WORD_W-2:0];
               run_armed = 1'b1;
            end else begin
               // marker on the last byte has no repeat byte: written once
               emit           = 1'b1;
               rsp.word_value = (word > MARKER_LIMIT) ? (word & MARKER_CLEAR) : word;
               rsp.run_length = LEN_W'(1);
            end
         end
         if (emit) begin
            dest_count += rsp.run_length;
            if (dest_count >= OUTPUT_CAPACITY)
               dest_full = 1'b1;
         end
      end
      rsp.end_of_copy   = last;
      rsp.words_written = dest_count[WCNT_W-1:0];
      if (last)
         clear_copy_state();
      return emit || last;
   endfunction

   function automatic void check_field(string field, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type predicted;
      if (reset) begin
         clear_copy_state();
         expected_rsp.delete();
         mismatches        = 0;
         pending_rsp_words = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (expand_byte(req_mon.data_byte, req_mon.last_byte, predicted))
               expected_rsp.push_back(predicted);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected rsp word, expected none, actual 0x%0h len %0d",
                        $time, rsp_mon.word_value, rsp_mon.run_length);
               mismatches++;
            end else begin
               predicted = expected_rsp.pop_front();
               check_field("word_value", predicted.word_value, rsp_mon.word_value);
               check_field("run_length", predicted.run_length, rsp_mon.run_length);
               check_field("end_of_copy", predicted.end_of_copy, rsp_mon.end_of_copy);
               check_field("words_written", predicted.words_written,
                           rsp_mon.words_written);
            end
         end
         pending_rsp_words = expected_rsp.size();
      end
   end

endmodule

// ----- verif/word_run_length_expander_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the word run-length expander: clock, reset, source byte
// stimulus, receiver stalls and the verdict. Depends on wrle_pkg, wrle_if.sv,
// the block and wrle_expand_check.
module word_run_length_expander_tb;
   import wrle_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int BYTES_PER_PHASE = 500;

   localparam int unsigned GAP_PCT[3]   = '{8, 73, 0};
   localparam int unsigned STALL_PCT[3] = '{73, 8, 0};

   logic              clock;
   logic              reset;
   int unsigned       send_gap_pct;
   int unsigned       rsp_stall_pct;
   int unsigned       mismatches;
   int unsigned       pending_rsp_words;
   int unsigned       cycle_count = 0;
   logic [BYTE_W-1:0] copy_bytes[$];

   wrle_req_if req_bus();
   wrle_rsp_if rsp_bus();

   word_run_length_expander DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   wrle_expand_check expander_check (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .mismatches        (mismatches),
      .pending_rsp_words (pending_rsp_words)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("word_run_length_expander test failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_copy();
      foreach (copy_bytes[i])
         send_byte(copy_bytes[i], i == copy_bytes.size() - 1);
      copy_bytes.delete();
   endtask

   // Hold the sender until every rsp word is in, then switch idling.
   task automatic drain_results(input int unsigned gap, input int unsigned stall);
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_rsp_words != 0);
      send_gap_pct  = gap;
      rsp_stall_pct = stall;
      @(posedge clock);
   endtask

   function automatic void add_word(input logic [WORD_W-1:0] w);
      for (int i = 0; i < 4; i++)
         copy_bytes.push_back(w[8*i +: 8]);
   endfunction

   // Mostly well-formed copies (plain words, runs, trailing partials),
   // some pure byte noise.
   function automatic void build_random_copy();
      int unsigned       kind;
      int unsigned       tail;
      bit                ends_on_marker;
      logic [WORD_W-1:0] w;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 30)) copy_bytes.push_back(BYTE_W'($urandom_range(255)));
         return;
      end
      ends_on_marker = 1'b0;
      repeat ($urandom_range(1, 40)) begin
         w              = $urandom();
         kind           = $urandom_range(9);
         ends_on_marker = 1'b0;
         if (kind < 4) begin
            w[WORD_W-1] = 1'b0;
            add_word(w);
         end else if (kind == 4) begin
            case ($urandom_range(2))
               0:       add_word(MARKER_LIMIT);
               1:       add_word(MARKER_CLEAR);
               default: add_word('0);
            endcase
         end else begin
            w[WORD_W-1] = 1'b1;
            if (w == MARKER_LIMIT)
               w[0] = 1'b1;
            add_word(w);
            copy_bytes.push_back(BYTE_W'(($urandom_range(4) == 0) ? $urandom_range(255)
                                                                  : $urandom_range(7)));
            ends_on_marker = 1'b1;
         end
      end
      tail = $urandom_range(3);
      if (tail == 0 && ends_on_marker && $urandom_range(1))
         void'(copy_bytes.pop_back());
      repeat (tail) copy_bytes.push_back(BYTE_W'($urandom_range(255)));
   endfunction

   initial begin
      int unsigned phase_bytes;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      send_gap_pct      = GAP_PCT[0];
      rsp_stall_pct     = STALL_PCT[0];
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // run reaching capacity; its repeat byte is the last byte
      add_word(32'hFFFF_FFFF);
      copy_bytes.push_back(8'hFF);
      send_copy();
      // 0x80000000 is a plain word; trailing partial word dropped
      add_word(MARKER_LIMIT);
      copy_bytes.push_back(8'h5A);
      copy_bytes.push_back(8'hA5);
      send_copy();
      // single-copy run, then a marker on the last byte
      add_word(32'h8000_0001);
      copy_bytes.push_back(8'h00);
      add_word(32'hFFFF_FFFF);
      send_copy();
      // capacity full: later bytes ignored until the last byte
      add_word(32'h8000_00AA);
      copy_bytes.push_back(8'd254);
      add_word(MARKER_CLEAR);
      copy_bytes.push_back(8'h3C);
      send_copy();
      drain_results(GAP_PCT[0], STALL_PCT[0]);

      for (int phase = 0; phase < 3; phase++) begin
         phase_bytes = 0;
         while (phase_bytes < BYTES_PER_PHASE) begin
            build_random_copy();
            phase_bytes += copy_bytes.size();
            send_copy();
         end
         if (phase < 2)
            drain_results(GAP_PCT[phase+1], STALL_PCT[phase+1]);
      end
      drain_results(0, 0);
      repeat (8) @(negedge clock);

      if (mismatches == 0 && pending_rsp_words == 0)
         $display("word_run_length_expander test passed");
      else
         $display("word_run_length_expander test failed");
      $finish;
   end

endmodule

// ----- files.f -----
sv/wrle_pkg.sv
sv/wrle_if.sv
sv/word_run_length_expander.sv
verif/wrle_expand_check.sv
verif/word_run_length_expander_tb.sv
